FILE: design/fscd_pkg.sv
// Shared constants, codes and types of the force step change detector.
// No dependencies; every design file imports this package.
package fscd_pkg;

    // Sizing of the sample path
    localparam int RING_DEPTH   = 10;
    localparam int SAMPLE_WIDTH = 24;
    localparam int NUM_AXES     = 6;
    localparam int PTR_W        = $clog2(RING_DEPTH);
    localparam int SUM_W        = SAMPLE_WIDTH + PTR_W;
    localparam int ABS_W        = SUM_W - 1;

    // Reciprocal for the divide by RING_DEPTH: exact for every ABS_W-bit dividend
    localparam int DIV_SHIFT          = ABS_W + PTR_W;
    localparam int RECIP_W            = SUM_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    // Register fields
    localparam int THRESH_W   = 24;
    localparam int COUNT_W    = 16;
    localparam int AXIS_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int DIFF_W     = ((SAMPLE_WIDTH > THRESH_W) ? SAMPLE_WIDTH : THRESH_W) + 1;

    // Stream widths
    localparam int S_TDATA_W = ((NUM_AXES * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int M_TUSER_W = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_SELECT   = 2'd2;

    // Axis codes
    localparam logic [AXIS_W-1:0] AXIS_FORCE_X  = 3'd0;
    localparam logic [AXIS_W-1:0] AXIS_FORCE_Y  = 3'd1;
    localparam logic [AXIS_W-1:0] AXIS_FORCE_Z  = 3'd2;
    localparam logic [AXIS_W-1:0] AXIS_TORQUE_X = 3'd3;
    localparam logic [AXIS_W-1:0] AXIS_TORQUE_Y = 3'd4;
    localparam logic [AXIS_W-1:0] AXIS_TORQUE_Z = 3'd5;

    // Register reset values
    localparam logic [COUNT_W-1:0] CONFIRM_RESET = 16'd1;

    // Stop causes
    localparam logic [1:0] CAUSE_RUNNING   = 2'd0;
    localparam logic [1:0] CAUSE_TRIGGER   = 2'd1;
    localparam logic [1:0] CAUSE_CONFIRMED = 2'd2;

    typedef struct packed {
        logic signed [THRESH_W-1:0] threshold;
        logic [COUNT_W-1:0]         confirm_count;
        logic [AXIS_W-1:0]          axis_select;
    } fscd_cfg_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    wrap;
    } fscd_ring_stat_t;

    typedef struct packed {
        logic                        keep_going;
        logic [1:0]                  stop_cause;
        logic                        baseline_ready;
        logic signed [SAMPLE_WIDTH-1:0] average;
    } fscd_result_t;

endpackage

FILE: design/fscd_ring.sv
// Sample ring: axis selection, negation, ring store and running sum.
// Depends on fscd_pkg.
module fscd_ring (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       step,
    input  logic                                       trig,
    input  logic [fscd_pkg::NUM_AXES*fscd_pkg::SAMPLE_WIDTH-1:0] samples,
    input  logic [fscd_pkg::AXIS_W-1:0]                axis_select,
    output fscd_pkg::fscd_ring_stat_t                  stat
);
    import fscd_pkg::*;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = ~SAMPLE_MIN;

    logic signed [SAMPLE_WIDTH-1:0] ring_reg [RING_DEPTH];
    logic [PTR_W-1:0]               ptr_reg;
    logic [PTR_W-1:0]               ptr_next;
    logic signed [SUM_W-1:0]        sum_reg;
    logic signed [SUM_W-1:0]        sum_next;
    logic signed [SAMPLE_WIDTH-1:0] raw;
    logic signed [SAMPLE_WIDTH-1:0] x;
    logic                           last;

    // Pick the watched component; the unused codes fall on torque z
    always_comb begin
        case (axis_select)
            AXIS_FORCE_X:  raw = samples[0*SAMPLE_WIDTH +: SAMPLE_WIDTH];
            AXIS_FORCE_Y:  raw = samples[1*SAMPLE_WIDTH +: SAMPLE_WIDTH];
            AXIS_FORCE_Z:  raw = samples[2*SAMPLE_WIDTH +: SAMPLE_WIDTH];
            AXIS_TORQUE_X: raw = samples[3*SAMPLE_WIDTH +: SAMPLE_WIDTH];
            AXIS_TORQUE_Y: raw = samples[4*SAMPLE_WIDTH +: SAMPLE_WIDTH];
            default:       raw = samples[5*SAMPLE_WIDTH +: SAMPLE_WIDTH];
        endcase
    end

    // Negate, saturating the most negative code
    assign x = (raw == SAMPLE_MIN) ? SAMPLE_MAX : -raw;

    // Running sum and pointer update
    assign last     = (ptr_reg == PTR_W'(RING_DEPTH - 1));
    assign ptr_next = last ? '0 : ptr_reg + 1'b1;
    assign sum_next = sum_reg + SUM_W'(x) - SUM_W'(ring_reg[ptr_reg]);

    // A trigger transaction sees the sum as it stands
    assign stat.sum  = trig ? sum_reg : sum_next;
    assign stat.wrap = last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
            sum_reg <= '0;
            for (int i = 0; i < RING_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
        end else if (step) begin
            ring_reg[ptr_reg] <= x;
            ptr_reg           <= ptr_next;
            sum_reg           <= sum_next;
        end
    end

endmodule

FILE: design/fscd_avg.sv
// Ring average: signed sum divided by the ring depth, truncated toward zero.
// Reciprocal multiply on the magnitude; depends on fscd_pkg.
module fscd_avg (
    input  logic signed [fscd_pkg::SUM_W-1:0]        sum,
    output logic signed [fscd_pkg::SAMPLE_WIDTH-1:0] average
);
    import fscd_pkg::*;

    logic                          neg;
    logic [SUM_W-1:0]              mag_full;
    logic [ABS_W-1:0]              mag;
    logic [ABS_W+RECIP_W-1:0]      prod;
    logic [SAMPLE_WIDTH-2:0]       quo;

    // Magnitude always fits below the sign bit
    assign neg      = sum[SUM_W-1];
    assign mag_full = neg ? $unsigned(-sum) : $unsigned(sum);
    assign mag      = mag_full[ABS_W-1:0];

    // Exact quotient from the rounded-up reciprocal
    assign prod = (ABS_W+RECIP_W)'(mag) * (ABS_W+RECIP_W)'(RECIP);
    assign quo  = prod[DIV_SHIFT +: SAMPLE_WIDTH-1];

    assign average = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

endmodule

FILE: design/fscd_decide.sv
// Baseline latch, threshold compare and confirmation counter.
// Depends on fscd_pkg.
module fscd_decide (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     step,
    input  logic                                     trig,
    input  logic                                     wrap,
    input  logic signed [fscd_pkg::SAMPLE_WIDTH-1:0] average,
    input  fscd_pkg::fscd_cfg_t                      cfg,
    output fscd_pkg::fscd_result_t                   result,
    output logic                                     baseline_valid
);
    import fscd_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] baseline_reg, baseline_next;
    logic                           valid_reg, valid_next;
    logic                           confirming_reg, confirming_next;
    logic [COUNT_W-1:0]             lag_reg, lag_next;
    logic signed [DIFF_W-1:0]       diff;
    logic signed [DIFF_W-1:0]       thr;
    logic                           thr_pos, thr_neg, hit;
    logic [COUNT_W-1:0]             lag_load, lag_dec;

    // Change from baseline against the signed threshold
    assign diff    = DIFF_W'(average) - DIFF_W'(baseline_reg);
    assign thr     = DIFF_W'(cfg.threshold);
    assign thr_neg = cfg.threshold[THRESH_W-1];
    assign thr_pos = !thr_neg && (|cfg.threshold);
    assign hit     = (thr_pos && (diff > thr)) || (thr_neg && (diff < thr));

    // First hit of a run reloads; count stops at zero
    assign lag_load = confirming_reg ? lag_reg : cfg.confirm_count;
    assign lag_dec  = (lag_load != '0) ? lag_load - 1'b1 : '0;

    always_comb begin
        baseline_next     = baseline_reg;
        valid_next        = valid_reg;
        confirming_next   = confirming_reg;
        lag_next          = lag_reg;
        result.keep_going = 1'b1;
        result.stop_cause = CAUSE_RUNNING;
        if (trig) begin
            result.keep_going = 1'b0;
            result.stop_cause = CAUSE_TRIGGER;
        end else if (!valid_reg) begin
            if (wrap) begin
                valid_next    = 1'b1;
                baseline_next = average;
            end
        end else if (hit) begin
            confirming_next = 1'b1;
            lag_next        = lag_dec;
            if (lag_dec == '0) begin
                result.keep_going = 1'b0;
                result.stop_cause = CAUSE_CONFIRMED;
            end
        end else begin
            confirming_next = 1'b0;
        end
        result.baseline_ready = valid_next;
        result.average        = average;
    end

    assign baseline_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg   <= '0;
            valid_reg      <= 1'b0;
            confirming_reg <= 1'b0;
            lag_reg        <= CONFIRM_RESET;
        end else if (step) begin
            baseline_reg   <= baseline_next;
            valid_reg      <= valid_next;
            confirming_reg <= confirming_next;
            lag_reg        <= lag_next;
        end
    end

endmodule

FILE: design/force_step_change_detector.sv
// Force step change detector: input and result registers, config registers.
// Depends on fscd_pkg, fscd_ring, fscd_avg and fscd_decide.
//
// Usage:
//   s_ channel: one transaction per force/torque sample. s_tdata holds the six
//   components, s_tuser the trigger. m_ channel: one result transaction per
//   sample with the running ring average in m_tdata and the decision in
//   m_tuser. Registers are written on cfg_wr_en with cfg_index/cfg_wdata;
//   the user writes them only while no transaction is in flight; the block does not enforce this.
// Timing:
//   One transaction per cycle sustained while m_tready stays high. An accepted
//   sample is held in the input register and then processed into the result
//   register, which drives m_tvalid. The rate is set by the single pass between the
//   input and result registers: ring sum update, reciprocal multiply for the
//   average, baseline compare and confirmation counter all lie in that pass.
// Reset and stall:
//   aresetn (synchronous, low) clears the ring, pointer, sum and baseline,
//   sets the confirmation counter to 1 and loads threshold 0, confirm_count 1,
//   axis_select force z. When m_tready is low the result holds, the input
//   register takes one more sample, and s_tready then drops until the result is taken.
module force_step_change_detector (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // fields from bit 0: force_x, force_y, force_z, torque_x, torque_y, torque_z
    input  logic [fscd_pkg::S_TDATA_W-1:0]        s_tdata,
    // fields from bit 0: trigger
    input  logic [0:0]                            s_tuser,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // fields from bit 0: average
    output logic [fscd_pkg::M_TDATA_W-1:0]        m_tdata,
    // fields from bit 0: keep_going, stop_cause[1:0], baseline_ready
    output logic [fscd_pkg::M_TUSER_W-1:0]        m_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_wr_en,
    input  logic [fscd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fscd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import fscd_pkg::*;

    logic                                   in_valid_reg;
    logic [NUM_AXES*SAMPLE_WIDTH-1:0]       in_data_reg;
    logic                                   in_trig_reg;
    logic                                   out_valid_reg;
    fscd_result_t                           out_result_reg;
    fscd_cfg_t                              cfg_reg;
    fscd_ring_stat_t                        ring_stat;
    fscd_result_t                           result;
    logic signed [SAMPLE_WIDTH-1:0]         average;
    logic                                   baseline_valid;
    logic                                   adv;
    logic                                   step;

    // Handshake: the result register frees as it drains
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign step     = adv && !in_trig_reg;
    assign s_tready = !in_valid_reg || adv;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold     <= '0;
            cfg_reg.confirm_count <= CONFIRM_RESET;
            cfg_reg.axis_select   <= AXIS_FORCE_Z;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_THRESHOLD:     cfg_reg.threshold     <= cfg_wdata[THRESH_W-1:0];
                CFG_CONFIRM_COUNT: cfg_reg.confirm_count <= cfg_wdata[COUNT_W-1:0];
                CFG_AXIS_SELECT:   cfg_reg.axis_select   <= cfg_wdata[AXIS_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[NUM_AXES*SAMPLE_WIDTH-1:0];
            in_trig_reg <= s_tuser[0];
        end
    end

    fscd_ring u_ring (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .trig        (in_trig_reg),
        .samples     (in_data_reg),
        .axis_select (cfg_reg.axis_select),
        .stat        (ring_stat)
    );

    fscd_avg u_avg (
        .sum     (ring_stat.sum),
        .average (average)
    );

    fscd_decide u_decide (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .trig           (in_trig_reg),
        .wrap           (ring_stat.wrap),
        .average        (average),
        .cfg            (cfg_reg),
        .result         (result),
        .baseline_valid (baseline_valid)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'($unsigned(out_result_reg.average));
    assign m_tuser  = {out_result_reg.baseline_ready, out_result_reg.stop_cause,
                       out_result_reg.keep_going};

`ifndef SYNTHESIS
    // Stop is reported exactly when a cause is given
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] == (m_tuser[2:1] == CAUSE_RUNNING)))
        else $error("keep_going disagrees with stop_cause");

    // A trigger transaction comes out as a trigger stop
    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_trig_reg) |=> (m_tvalid && m_tuser[2:1] == CAUSE_TRIGGER))
        else $error("trigger transaction not reported as trigger stop");

    // Confirmed change is only possible with a baseline
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2:1] == CAUSE_CONFIRMED) |-> m_tuser[3])
        else $error("confirmed stop without baseline");

    // Once latched, the baseline stays latched
    assert property (@(posedge aclk) disable iff (!aresetn)
        baseline_valid |=> baseline_valid)
        else $error("baseline valid dropped");
`endif

endmodule
